@@ hw/rtl/cfa_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfa_pkg
// Shared types and codes of the call-frame rule table engine: request and
// result layouts, opcodes, rule kinds, configuration indexes and states.
// ----------------------------------------------------------------------------
package cfa_pkg;

  // opcodes of an input request, values match the cmd field
  typedef enum logic [3:0] {
    OP_SET_LOC       = 4'd0,
    OP_ADVANCE       = 4'd1,
    OP_OFFSET        = 4'd2,
    OP_REGISTER      = 4'd3,
    OP_DEF_FRAME     = 4'd4,
    OP_DEF_FRAME_REG = 4'd5,
    OP_DEF_FRAME_OFF = 4'd6,
    OP_FIXUP         = 4'd7,
    OP_FIXUP_PTR     = 4'd8,
    OP_NOP           = 4'd9,
    OP_BEGIN         = 4'd10,
    OP_BAD           = 4'd11
  } cfa_op_e;

  // highest cmd code that names a real opcode
  localparam logic [3:0] CMD_LAST = 4'd10;

  // rule kinds kept in a table entry
  typedef enum logic [2:0] {
    KIND_UNDEF     = 3'd0,
    KIND_OFFSET    = 3'd1,
    KIND_REGISTER  = 3'd2,
    KIND_FRAME     = 3'd3,
    KIND_FIXUP     = 3'd4,
    KIND_FIXUP_PTR = 3'd5
  } cfa_kind_e;

  // configuration register indexes
  localparam logic [1:0] CFG_START_LOC = 2'd0;
  localparam logic [1:0] CFG_STOP_LOC  = 2'd1;
  localparam logic [1:0] CFG_STOP_EN   = 2'd2;

  // back end sequencer states
  typedef enum logic {
    BK_READ,
    BK_EXEC
  } cfa_bstate_e;

  // input request
  typedef struct packed {
    logic [3:0]         cmd;
    logic [4:0]         target_reg;
    logic [4:0]         source_reg;
    logic [31:0]        amount;
    logic signed [31:0] rule_offset;
    logic [15:0]        fixup_index;
  } cfa_in_t;

  // result
  typedef struct packed {
    logic [31:0]        location;
    logic               stopped;
    logic               error;
    logic               entry_is_frame;
    logic [4:0]         entry_reg;
    logic [2:0]         entry_kind;
    logic [4:0]         entry_source_reg;
    logic signed [31:0] entry_offset;
    logic [15:0]        entry_index;
    logic               entry_valid;
  } cfa_res_t;

  // one rule table entry
  typedef struct packed {
    cfa_kind_e          kind;
    logic [4:0]         src;
    logic signed [31:0] offset;
    logic [15:0]        index;
  } cfa_entry_t;

  // classified request handed from front to back
  typedef struct packed {
    cfa_op_e            op;
    logic               touches;
    logic               is_frame;
    logic [4:0]         target_reg;
    logic [4:0]         source_reg;
    logic [31:0]        amount;
    logic signed [31:0] rule_offset;
    logic [15:0]        fixup_index;
  } cfa_cmd_t;

  // configuration seen by the back end
  typedef struct packed {
    logic [31:0] start_location;
    logic [31:0] stop_location;
    logic        stop_enable;
  } cfa_cfg_t;

endpackage
`default_nettype wire

@@ hw/rtl/cfa_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfa_fifo
// Two-entry queue of DW-bit words with full and empty flags.
// ----------------------------------------------------------------------------
module cfa_fifo #(
  parameter int unsigned DW = 8
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire logic [DW-1:0] data_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic [DW-1:0]      data_o,
  output logic               empty_o
);

  logic [DW-1:0] slot_q [2];
  logic          wr_ptr_q;
  logic          rd_ptr_q;
  logic [1:0]    cnt_q;
  logic          do_push;
  logic          do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = slot_q[rd_ptr_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= ~wr_ptr_q;
      if (do_pop) rd_ptr_q <= ~rd_ptr_q;
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) slot_q[wr_ptr_q] <= data_i;
  end

endmodule
`default_nettype wire

@@ hw/rtl/cfa_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfa_front
// Takes input requests, decodes the opcode, works out which table entry a
// request touches and queues the classified request for the back end.
// ----------------------------------------------------------------------------
module cfa_front
  import cfa_pkg::*;
#(
  parameter int unsigned NUM_REGS = 32
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    push_i,
  input  wire cfa_in_t in_item_i,
  output logic         full_o,
  input  wire logic    q_pop_i,
  output cfa_cmd_t     q_cmd_o,
  output logic         q_empty_o
);

  localparam int unsigned AW = $clog2(NUM_REGS + 1);
  localparam int unsigned CW = (AW > 5) ? AW : 5;
  localparam int unsigned QW = $bits(cfa_cmd_t);

  cfa_cmd_t      cmd;
  logic          in_range;
  logic [QW-1:0] q_data;

  assign in_range = (CW'(in_item_i.target_reg) < CW'(NUM_REGS));

  // opcode decode and entry classification
  always_comb begin
    cmd             = '0;
    cmd.target_reg  = in_item_i.target_reg;
    cmd.source_reg  = in_item_i.source_reg;
    cmd.amount      = in_item_i.amount;
    cmd.rule_offset = in_item_i.rule_offset;
    cmd.fixup_index = in_item_i.fixup_index;
    if (in_item_i.cmd <= CMD_LAST) begin
      cmd.op = cfa_op_e'(in_item_i.cmd);
    end else begin
      cmd.op = OP_BAD;
    end
    unique case (cmd.op) inside
      OP_DEF_FRAME, OP_DEF_FRAME_REG, OP_DEF_FRAME_OFF: begin
        cmd.touches  = 1'b1;
        cmd.is_frame = 1'b1;
      end
      OP_OFFSET, OP_REGISTER, OP_FIXUP, OP_FIXUP_PTR: begin
        cmd.touches  = in_range;
        cmd.is_frame = 1'b0;
      end
      default: begin
        cmd.touches  = 1'b0;
        cmd.is_frame = 1'b0;
      end
    endcase
  end

  // request queue toward the back end
  cfa_fifo #(
    .DW (QW)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .data_i  (cmd),
    .full_o  (full_o),
    .pop_i   (q_pop_i),
    .data_o  (q_data),
    .empty_o (q_empty_o)
  );

  assign q_cmd_o = cfa_cmd_t'(q_data);

endmodule
`default_nettype wire

@@ hw/rtl/cfa_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfa_back
// Executes classified requests: keeps location and stop flag, does the
// read-modify-write of the rule table memory and queues the results.
// ----------------------------------------------------------------------------
module cfa_back
  import cfa_pkg::*;
#(
  parameter int unsigned NUM_REGS = 32
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire cfa_cfg_t cfg_i,
  input  wire logic     q_empty_i,
  input  wire cfa_cmd_t q_cmd_i,
  output logic          q_pop_o,
  output logic          res_empty_o,
  input  wire logic     res_pop_i,
  output cfa_res_t      res_item_o
);

  localparam int unsigned DEPTH = NUM_REGS + 1;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned RW    = $bits(cfa_res_t);

  cfa_bstate_e      state_q, state_d;
  cfa_cmd_t         cmd_q;
  logic [AW-1:0]    addr_q;
  logic [AW-1:0]    rd_addr;
  cfa_entry_t       mem [DEPTH];
  cfa_entry_t       rd_q;
  logic [DEPTH-1:0] valid_q;
  logic [31:0]      loc_q, loc_d;
  logic             stop_q, stop_d;
  cfa_entry_t       cur_entry;
  cfa_entry_t       new_entry;
  logic             ignore;
  logic             mem_we;
  logic             res_push;
  logic             res_full;
  cfa_res_t         res;
  logic [RW-1:0]    res_data;

  // entry address of the request at the head of the queue
  assign rd_addr = q_cmd_i.is_frame ? AW'(NUM_REGS) : AW'(q_cmd_i.target_reg);

  // sequencer: read the entry, then update it and report
  always_comb begin
    state_d  = state_q;
    q_pop_o  = 1'b0;
    res_push = 1'b0;
    unique case (state_q)
      BK_READ: begin
        if (!q_empty_i && !res_full) begin
          q_pop_o = 1'b1;
          state_d = BK_EXEC;
        end
      end
      BK_EXEC: begin
        res_push = 1'b1;
        state_d  = BK_READ;
      end
      default: state_d = BK_READ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_READ;
    end else begin
      state_q <= state_d;
    end
  end

  // latch the popped request
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cmd_q  <= q_cmd_i;
      addr_q <= rd_addr;
    end
  end

  // entry merge, location move and stop check
  always_comb begin
    ignore    = stop_q && (cmd_q.op != OP_BEGIN);
    cur_entry = valid_q[addr_q] ? rd_q : '0;
    new_entry = cur_entry;
    loc_d     = loc_q;
    stop_d    = stop_q;
    case (cmd_q.op) inside
      OP_OFFSET: begin
        new_entry.kind   = KIND_OFFSET;
        new_entry.offset = cmd_q.rule_offset;
      end
      OP_REGISTER: begin
        new_entry.kind = KIND_REGISTER;
        new_entry.src  = cmd_q.source_reg;
      end
      OP_FIXUP, OP_FIXUP_PTR: begin
        new_entry.kind  = (cmd_q.op == OP_FIXUP) ? KIND_FIXUP : KIND_FIXUP_PTR;
        new_entry.src   = cmd_q.source_reg;
        new_entry.index = cmd_q.fixup_index;
      end
      OP_DEF_FRAME: begin
        new_entry.kind   = KIND_FRAME;
        new_entry.src    = cmd_q.target_reg;
        new_entry.offset = cmd_q.rule_offset;
      end
      OP_DEF_FRAME_REG: begin
        new_entry.kind = KIND_FRAME;
        new_entry.src  = cmd_q.target_reg;
      end
      OP_DEF_FRAME_OFF: begin
        new_entry.kind   = KIND_FRAME;
        new_entry.offset = signed'(cmd_q.amount);
      end
      default: new_entry = cur_entry;
    endcase
    if (cmd_q.op == OP_BEGIN) begin
      loc_d  = cfg_i.start_location;
      stop_d = 1'b0;
    end else if (!ignore && (cmd_q.op == OP_SET_LOC || cmd_q.op == OP_ADVANCE)) begin
      loc_d = (cmd_q.op == OP_SET_LOC) ? cmd_q.amount : loc_q + cmd_q.amount;
      if (cfg_i.stop_enable && (loc_d > cfg_i.stop_location)) stop_d = 1'b1;
    end
    mem_we = (state_q == BK_EXEC) && !ignore && cmd_q.touches;

    res                  = '0;
    res.location         = loc_d;
    res.stopped          = stop_d;
    res.error            = !ignore && (cmd_q.op == OP_BAD);
    if (!ignore && cmd_q.touches) begin
      res.entry_is_frame   = cmd_q.is_frame;
      res.entry_reg        = cmd_q.is_frame ? 5'd0 : cmd_q.target_reg;
      res.entry_kind       = new_entry.kind;
      res.entry_source_reg = new_entry.src;
      res.entry_offset     = new_entry.offset;
      res.entry_index      = new_entry.index;
      res.entry_valid      = 1'b1;
    end
  end

  // location, stop flag and entry valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loc_q   <= '0;
      stop_q  <= 1'b0;
      valid_q <= '0;
    end else if (state_q == BK_EXEC) begin
      loc_q  <= loc_d;
      stop_q <= stop_d;
      if (cmd_q.op == OP_BEGIN) begin
        valid_q <= '0;
      end else if (mem_we) begin
        valid_q[addr_q] <= 1'b1;
      end
    end
  end

  // rule table memory
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[addr_q] <= new_entry;
    if (q_pop_o) rd_q <= mem[rd_addr];
  end

  // result queue
  cfa_fifo #(
    .DW (RW)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res),
    .full_o  (res_full),
    .pop_i   (res_pop_i),
    .data_o  (res_data),
    .empty_o (res_empty_o)
  );

  assign res_item_o = cfa_res_t'(res_data);

endmodule
`default_nettype wire

@@ hw/rtl/cfa_rule_table_engine.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfa_rule_table_engine
// Call-frame instruction interpreter building a per-register rule table.
// ----------------------------------------------------------------------------
// Each request passes the execution unit in a read state, which fetches the
// touched entry from the rule table memory, and an execute state, which
// merges, writes it back and reports; a new request is taken only once the
// last one is reported. A two-entry request queue and a two-entry result
// queue let input and output stall independently; a request passes the
// request queue, both states and the result queue before its result appears.
// The table needs no clearing pass: per-entry valid bits are cleared by
// reset and by a begin request. Configuration writes are always ready and
// should only be issued while the block is idle.
module cfa_rule_table_engine
  import cfa_pkg::*;
#(
  parameter int unsigned NUM_REGS = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  input  wire cfa_in_t     in_item_i,
  output logic             full,
  output logic             empty,
  input  wire logic        pop,
  output cfa_res_t         res_item_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i
);

  cfa_cfg_t cfg_q;
  cfa_cmd_t q_cmd;
  logic     q_pop;
  logic     q_empty;

  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_START_LOC: cfg_q.start_location <= cfg_data_i;
        CFG_STOP_LOC:  cfg_q.stop_location  <= cfg_data_i;
        CFG_STOP_EN:   cfg_q.stop_enable    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // decode and request queue
  cfa_front #(
    .NUM_REGS (NUM_REGS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .in_item_i (in_item_i),
    .full_o    (full),
    .q_pop_i   (q_pop),
    .q_cmd_o   (q_cmd),
    .q_empty_o (q_empty)
  );

  // execution and result queue
  cfa_back #(
    .NUM_REGS (NUM_REGS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_empty_i   (q_empty),
    .q_cmd_i     (q_cmd),
    .q_pop_o     (q_pop),
    .res_empty_o (empty),
    .res_pop_i   (pop),
    .res_item_o  (res_item_o)
  );

endmodule
`default_nettype wire

@@ hw/rtl/cfa_chk.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfa_chk
// Port-level checks on the results of the rule table engine.
// ----------------------------------------------------------------------------
module cfa_chk
  import cfa_pkg::*;
(
  input wire logic     clk_i,
  input wire logic     rst_ni,
  input wire logic     empty,
  input wire logic     pop,
  input wire cfa_res_t res_item_o
);

  // a waiting result holds until taken
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(res_item_o)))
    else $error("result changed while stalled");

  // an error or a stopped request never touches an entry, and no result is both
  a_err_no_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (res_item_o.error || res_item_o.stopped)) |->
      (!res_item_o.entry_valid && !(res_item_o.error && res_item_o.stopped)))
    else $error("error or stopped result touched an entry");

  // the frame entry is always of frame kind and reports register zero
  a_frame_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && res_item_o.entry_is_frame) |->
      (res_item_o.entry_valid && res_item_o.entry_kind == KIND_FRAME &&
       res_item_o.entry_reg == 5'd0))
    else $error("bad frame entry result");

  // untouched results carry zero entry fields
  a_no_entry_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !res_item_o.entry_valid) |->
      (res_item_o.entry_kind == KIND_UNDEF && res_item_o.entry_source_reg == 5'd0 &&
       res_item_o.entry_offset == 32'sd0 && res_item_o.entry_index == 16'd0 &&
       !res_item_o.entry_is_frame && res_item_o.entry_reg == 5'd0))
    else $error("untouched result carries entry data");

endmodule

bind cfa_rule_table_engine cfa_chk u_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .empty      (empty),
  .pop        (pop),
  .res_item_o (res_item_o)
);
`default_nettype wire
